// ===== hdl/ptpp_pkg.sv =====
// shared constants, tables and types of the point to panorama pixel core
`timescale 1ns / 1ps

package ptpp_pkg;

    // field and register widths
    localparam int COORD_W      = 24;
    localparam int CFG_W        = 23;
    localparam int DIM_W        = 15;
    localparam int FIELD_W      = 14;
    localparam int IDX_W        = 2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_MIN_RANGE   = 2'd0;
    localparam logic [IDX_W-1:0] REG_PANO_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_PANO_HEIGHT = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] MIN_RANGE_RST   = CFG_W'(19661);
    localparam logic [DIM_W-1:0] PANO_WIDTH_RST  = DIM_W'(6720);
    localparam logic [DIM_W-1:0] PANO_HEIGHT_RST = DIM_W'(3360);
    localparam logic [DIM_W-1:0] FIELD_MAX       = DIM_W'((1 << FIELD_W) - 1);

    // cordic setup
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int PRESCALE     = 8;
    localparam int CORDIC_W     = COORD_W + PRESCALE + 4;
    localparam int ANG_W        = 34;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(1073741824);

    // arctangent of 2^-i in binary angle units, 2^32 per turn
    localparam logic signed [ANG_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331, 21354465, 10679838, 5340245,
        2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861,
        10430, 5215, 2608, 1304,
        652, 326, 163, 81
    };

    // squares and roots
    localparam int SQ_W         = 2 * COORD_W;
    localparam int MINSQ_W      = 2 * CFG_W;
    localparam int ROOT_W       = COORD_W;
    localparam int ISQRT_STEPS  = SQ_W / 2;

    // cosine quotient, q1.16
    localparam int COS_FRAC     = 16;
    localparam int COS_W        = COS_FRAC + 1;
    localparam int DIV_STEPS    = COS_W;
    localparam logic [COS_W-1:0] COS_ONE = COS_W'(1 << COS_FRAC);

    // pipeline timing
    localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
    localparam int MERGE_LAT    = (CORDIC_LAT > DIV_STEPS) ? CORDIC_LAT : DIV_STEPS;
    localparam int ANG_PAD      = MERGE_LAT - CORDIC_LAT;
    localparam int COS_PAD      = MERGE_LAT - DIV_STEPS;
    localparam int S_ROOT       = 3 + ISQRT_STEPS;
    localparam int S_MERGE      = S_ROOT + MERGE_LAT;
    localparam int S_LAST       = S_MERGE + 6;
    localparam int CTRL_LEN     = S_LAST - 3;
    localparam int XYZ_DLY      = S_ROOT - 1;

    // pixel arithmetic widths
    localparam int LO_W         = 26;
    localparam int TC_W         = ANG_W + COS_W + 1;
    localparam int PL_W         = LO_W + DIM_W;
    localparam int PH_W         = TC_W - LO_W + DIM_W + 1;
    localparam int RP_W         = ANG_W + DIM_W + 1;
    localparam int SUM_W        = PH_W + 1;
    localparam int COL_SHIFT    = 48 - LO_W;
    localparam int ROW_SHIFT    = 32;
    localparam int COL_OFF_W    = SUM_W - COL_SHIFT;
    localparam int ROW_OFF_W    = RP_W - ROW_SHIFT;
    localparam int PIX_W        = COL_OFF_W + 1;

    // control travelling with each point
    typedef struct packed {
        logic valid;
        logic near;
        logic zero;
    } ctrl_t;

    // one result transaction
    typedef struct packed {
        logic               in_range;
        logic [FIELD_W-1:0] column;
        logic [FIELD_W-1:0] row;
    } result_t;

endpackage

// ===== hdl/ptpp_isqrt.sv =====
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps

module ptpp_isqrt
(
    input  logic                           clk,
    input  logic                           en,
    input  logic [ptpp_pkg::SQ_W-1:0]      radicand,
    output logic [ptpp_pkg::ROOT_W-1:0]    root
);

    localparam int REM_W = ptpp_pkg::ROOT_W + 2;

    logic [ptpp_pkg::SQ_W-1:0]   val_reg  [ptpp_pkg::ISQRT_STEPS];
    logic [REM_W-1:0]            rem_reg  [ptpp_pkg::ISQRT_STEPS];
    logic [ptpp_pkg::ROOT_W-1:0] res_reg  [ptpp_pkg::ISQRT_STEPS];
    logic [ptpp_pkg::SQ_W-1:0]   val_next [ptpp_pkg::ISQRT_STEPS];
    logic [REM_W-1:0]            rem_next [ptpp_pkg::ISQRT_STEPS];
    logic [ptpp_pkg::ROOT_W-1:0] res_next [ptpp_pkg::ISQRT_STEPS];

    // restoring root step: bring down two bits, try subtracting 4*res+1
    always_comb
    begin
        logic [ptpp_pkg::SQ_W-1:0]   val_in;
        logic [REM_W-1:0]            rem_in;
        logic [ptpp_pkg::ROOT_W-1:0] res_in;
        logic [REM_W+1:0]            rem_sh;
        logic [REM_W+1:0]            trial;
        for (int k = 0; k < ptpp_pkg::ISQRT_STEPS; k++)
        begin
            if (k == 0)
            begin
                val_in = radicand;
                rem_in = '0;
                res_in = '0;
            end
            else
            begin
                val_in = val_reg[k-1];
                rem_in = rem_reg[k-1];
                res_in = res_reg[k-1];
            end
            rem_sh      = {rem_in, val_in[ptpp_pkg::SQ_W-1 -: 2]};
            trial       = {2'b00, res_in, 2'b01};
            val_next[k] = val_in << 2;
            if (rem_sh >= trial)
            begin
                rem_next[k] = REM_W'(rem_sh - trial);
                res_next[k] = {res_in[ptpp_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = REM_W'(rem_sh);
                res_next[k] = {res_in[ptpp_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ptpp_pkg::ISQRT_STEPS; k++)
            begin
                val_reg[k] <= val_next[k];
                rem_reg[k] <= rem_next[k];
                res_reg[k] <= res_next[k];
            end
        end
    end

    assign root = res_reg[ptpp_pkg::ISQRT_STEPS-1];

endmodule

// ===== hdl/ptpp_cordic.sv =====
// pipelined cordic vectoring unit, returns atan2(y_in, x_in)
`timescale 1ns / 1ps

module ptpp_cordic
(
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [ptpp_pkg::CORDIC_W-1:0]  x_in,
    input  logic signed [ptpp_pkg::CORDIC_W-1:0]  y_in,
    output logic signed [ptpp_pkg::ANG_W-1:0]     ang
);

    localparam int N = ptpp_pkg::CORDIC_STEPS + 1;

    logic signed [ptpp_pkg::CORDIC_W-1:0] x_reg  [N];
    logic signed [ptpp_pkg::CORDIC_W-1:0] y_reg  [N];
    logic signed [ptpp_pkg::ANG_W-1:0]    a_reg  [N];
    logic signed [ptpp_pkg::CORDIC_W-1:0] x_next [N];
    logic signed [ptpp_pkg::CORDIC_W-1:0] y_next [N];
    logic signed [ptpp_pkg::ANG_W-1:0]    a_next [N];

    // quadrant fold, then one micro-rotation per stage
    always_comb
    begin
        logic signed [ptpp_pkg::CORDIC_W-1:0] xs;
        logic signed [ptpp_pkg::CORDIC_W-1:0] ys;
        if (x_in < 0)
        begin
            if (y_in >= 0)
            begin
                x_next[0] = y_in;
                y_next[0] = -x_in;
                a_next[0] = ptpp_pkg::QUARTER_TURN;
            end
            else
            begin
                x_next[0] = -y_in;
                y_next[0] = x_in;
                a_next[0] = -ptpp_pkg::QUARTER_TURN;
            end
        end
        else
        begin
            x_next[0] = x_in;
            y_next[0] = y_in;
            a_next[0] = '0;
        end
        for (int i = 0; i < ptpp_pkg::CORDIC_STEPS; i++)
        begin
            xs = x_reg[i] >>> i;
            ys = y_reg[i] >>> i;
            if (y_reg[i] > 0)
            begin
                x_next[i+1] = x_reg[i] + ys;
                y_next[i+1] = y_reg[i] - xs;
                a_next[i+1] = a_reg[i] + ptpp_pkg::ATAN_TABLE[i];
            end
            else if (y_reg[i] < 0)
            begin
                x_next[i+1] = x_reg[i] - ys;
                y_next[i+1] = y_reg[i] + xs;
                a_next[i+1] = a_reg[i] - ptpp_pkg::ATAN_TABLE[i];
            end
            else
            begin
                // vector already on the axis: nothing moves from here on
                x_next[i+1] = x_reg[i];
                y_next[i+1] = y_reg[i];
                a_next[i+1] = a_reg[i];
            end
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N; i++)
            begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                a_reg[i] <= a_next[i];
            end
        end
    end

    assign ang = a_reg[N-1];

endmodule

// ===== hdl/point_to_panorama_pixel_core.sv =====
// Throughput: one point per cycle; a result that waits on out_stall parks in a skid register,
// so the input keeps flowing until both the output register and the skid register are full.
// The depth is set by the capture, square and sum stages, the two 24-step square root pipelines,
// the 17-stage cordic and cosine divider stages and six stages of pixel arithmetic.
// Reset clears all valid bits and loads the register defaults; there is no clearing pass.
`timescale 1ns / 1ps

module point_to_panorama_pixel_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_we,
    input  logic [ptpp_pkg::IDX_W-1:0]           cfg_index,
    input  logic [ptpp_pkg::CFG_W-1:0]           cfg_data,
    // point channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [ptpp_pkg::COORD_W-1:0]  point_x,
    input  logic signed [ptpp_pkg::COORD_W-1:0]  point_y,
    input  logic signed [ptpp_pkg::COORD_W-1:0]  point_z,
    // pixel channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 in_range,
    output logic [ptpp_pkg::FIELD_W-1:0]         pixel_column,
    output logic [ptpp_pkg::FIELD_W-1:0]         pixel_row
);

    // configuration registers
    logic [ptpp_pkg::CFG_W-1:0]   min_range_reg;
    logic [ptpp_pkg::DIM_W-1:0]   pano_width_reg;
    logic [ptpp_pkg::DIM_W-1:0]   pano_height_reg;
    logic [ptpp_pkg::MINSQ_W-1:0] min_sq_reg;

    // pipeline enable
    logic en;

    // front stages
    logic                                 v1_reg, v2_reg, v3_reg;
    logic signed [ptpp_pkg::COORD_W-1:0]  x1_reg, y1_reg;
    logic signed [ptpp_pkg::COORD_W:0]    z1_reg;
    logic [ptpp_pkg::SQ_W-1:0]            sqx_reg, sqy_reg, sqz_reg;
    logic [ptpp_pkg::SQ_W-1:0]            rho2_reg, r2_reg;
    logic signed [2*ptpp_pkg::COORD_W-1:0] xx_full, yy_full;
    logic signed [2*ptpp_pkg::COORD_W+1:0] zz_full;

    // control line and coordinate delay line
    ptpp_pkg::ctrl_t                      ctrl_reg [ptpp_pkg::CTRL_LEN];
    logic signed [ptpp_pkg::COORD_W-1:0]  xd_reg [ptpp_pkg::XYZ_DLY];
    logic signed [ptpp_pkg::COORD_W-1:0]  yd_reg [ptpp_pkg::XYZ_DLY];
    logic signed [ptpp_pkg::COORD_W:0]    zd_reg [ptpp_pkg::XYZ_DLY];

    // roots and angle units
    logic [ptpp_pkg::ROOT_W-1:0]          rho_root, r_root;
    logic signed [ptpp_pkg::CORDIC_W-1:0] th_x, th_y, ph_x, ph_y;
    logic signed [ptpp_pkg::ANG_W-1:0]    ang_theta, ang_phi;
    logic signed [ptpp_pkg::ANG_W-1:0]    ang_theta_m, ang_phi_m;

    // cosine divider
    logic [ptpp_pkg::ROOT_W-1:0]  div_rem_reg  [ptpp_pkg::DIV_STEPS];
    logic [ptpp_pkg::ROOT_W-1:0]  div_dsr_reg  [ptpp_pkg::DIV_STEPS];
    logic [ptpp_pkg::COS_W-1:0]   div_quo_reg  [ptpp_pkg::DIV_STEPS];
    logic [ptpp_pkg::ROOT_W-1:0]  div_rem_next [ptpp_pkg::DIV_STEPS];
    logic [ptpp_pkg::ROOT_W-1:0]  div_dsr_next [ptpp_pkg::DIV_STEPS];
    logic [ptpp_pkg::COS_W-1:0]   div_quo_next [ptpp_pkg::DIV_STEPS];
    logic [ptpp_pkg::COS_W-1:0]   cos_m;

    // pixel arithmetic stages
    logic signed [ptpp_pkg::ANG_W-1:0]     theta_reg, phi_reg;
    logic [ptpp_pkg::COS_W-1:0]            cos_reg;
    logic signed [ptpp_pkg::TC_W-1:0]      tc_reg;
    logic signed [ptpp_pkg::RP_W-1:0]      rp_reg, rp2_reg;
    logic [ptpp_pkg::PL_W-1:0]             pl_reg;
    logic signed [ptpp_pkg::PH_W-1:0]      ph_reg;
    logic signed [ptpp_pkg::SUM_W-1:0]     col_sum;
    logic signed [ptpp_pkg::COL_OFF_W-1:0] col_off_reg;
    logic signed [ptpp_pkg::ROW_OFF_W-1:0] row_off_reg;
    logic signed [ptpp_pkg::PIX_W-1:0]     col_reg, row_reg;
    logic [ptpp_pkg::FIELD_W-1:0]          col_c_reg, row_c_reg;

    // output register and skid register
    ptpp_pkg::result_t out_reg, skid_reg, item;
    logic              out_valid_reg, skid_valid_reg;
    logic              out_valid_next, skid_valid_next;
    logic              out_ready, last_valid;
    logic              load_out, load_skid, out_from_skid;

    // saturate a pixel coordinate to the panorama and the field
    function automatic logic [ptpp_pkg::FIELD_W-1:0] clamp_pixel
    (
        input logic signed [ptpp_pkg::PIX_W-1:0] v,
        input logic [ptpp_pkg::DIM_W-1:0]        size
    );
        logic [ptpp_pkg::DIM_W-1:0]       hi;
        logic [ptpp_pkg::FIELD_W-1:0]     res;
        hi = size - 1'b1;
        if (hi > ptpp_pkg::FIELD_MAX)
            hi = ptpp_pkg::FIELD_MAX;
        if (size == '0)
            res = '0;
        else if (v < 0)
            res = '0;
        else if (v > $signed(ptpp_pkg::PIX_W'(hi)))
            res = hi[ptpp_pkg::FIELD_W-1:0];
        else
            res = v[ptpp_pkg::FIELD_W-1:0];
        return res;
    endfunction

    // configuration writes, out-of-list indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_range_reg   <= ptpp_pkg::MIN_RANGE_RST;
            pano_width_reg  <= ptpp_pkg::PANO_WIDTH_RST;
            pano_height_reg <= ptpp_pkg::PANO_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ptpp_pkg::REG_MIN_RANGE:   min_range_reg   <= cfg_data;
                ptpp_pkg::REG_PANO_WIDTH:  pano_width_reg  <= cfg_data[ptpp_pkg::DIM_W-1:0];
                ptpp_pkg::REG_PANO_HEIGHT: pano_height_reg <= cfg_data[ptpp_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // squared minimum range, refreshed every cycle
    always_ff @(posedge clk)
    begin
        min_sq_reg <= min_range_reg * min_range_reg;
    end

    // pipeline moves whenever the skid register is free
    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // front valid bits and control line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int k = 0; k < ptpp_pkg::CTRL_LEN; k++)
                ctrl_reg[k] <= '0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            ctrl_reg[0].valid <= v3_reg;
            ctrl_reg[0].near  <= r2_reg < {{(ptpp_pkg::SQ_W-ptpp_pkg::MINSQ_W){1'b0}}, min_sq_reg};
            ctrl_reg[0].zero  <= r2_reg == '0;
            for (int k = 1; k < ptpp_pkg::CTRL_LEN; k++)
                ctrl_reg[k] <= ctrl_reg[k-1];
        end
    end

    // full-width squares
    always_comb
    begin
        xx_full = x1_reg * x1_reg;
        yy_full = y1_reg * y1_reg;
        zz_full = z1_reg * z1_reg;
    end

    // input capture, squares, sums, coordinate delay line
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg   <= point_x;
            y1_reg   <= point_y;
            z1_reg   <= -$signed({point_z[ptpp_pkg::COORD_W-1], point_z});
            sqx_reg  <= xx_full[ptpp_pkg::SQ_W-1:0];
            sqy_reg  <= yy_full[ptpp_pkg::SQ_W-1:0];
            sqz_reg  <= zz_full[ptpp_pkg::SQ_W-1:0];
            rho2_reg <= sqx_reg + sqy_reg;
            r2_reg   <= sqx_reg + sqy_reg + sqz_reg;
            xd_reg[0] <= x1_reg;
            yd_reg[0] <= y1_reg;
            zd_reg[0] <= z1_reg;
            for (int k = 1; k < ptpp_pkg::XYZ_DLY; k++)
            begin
                xd_reg[k] <= xd_reg[k-1];
                yd_reg[k] <= yd_reg[k-1];
                zd_reg[k] <= zd_reg[k-1];
            end
        end
    end

    // horizontal and full radius roots
    ptpp_isqrt u_rho_sqrt
    (
        .clk      (clk),
        .en       (en),
        .radicand (rho2_reg),
        .root     (rho_root)
    );

    ptpp_isqrt u_r_sqrt
    (
        .clk      (clk),
        .en       (en),
        .radicand (r2_reg),
        .root     (r_root)
    );

    // cordic operands scaled up by the prescale
    assign th_x = {{(ptpp_pkg::CORDIC_W-ptpp_pkg::COORD_W-ptpp_pkg::PRESCALE)
                     {xd_reg[ptpp_pkg::XYZ_DLY-1][ptpp_pkg::COORD_W-1]}},
                   xd_reg[ptpp_pkg::XYZ_DLY-1], {ptpp_pkg::PRESCALE{1'b0}}};
    assign th_y = {{(ptpp_pkg::CORDIC_W-ptpp_pkg::COORD_W-ptpp_pkg::PRESCALE)
                     {yd_reg[ptpp_pkg::XYZ_DLY-1][ptpp_pkg::COORD_W-1]}},
                   yd_reg[ptpp_pkg::XYZ_DLY-1], {ptpp_pkg::PRESCALE{1'b0}}};
    assign ph_y = {{(ptpp_pkg::CORDIC_W-ptpp_pkg::COORD_W-1-ptpp_pkg::PRESCALE)
                     {zd_reg[ptpp_pkg::XYZ_DLY-1][ptpp_pkg::COORD_W]}},
                   zd_reg[ptpp_pkg::XYZ_DLY-1], {ptpp_pkg::PRESCALE{1'b0}}};
    assign ph_x = {{(ptpp_pkg::CORDIC_W-ptpp_pkg::ROOT_W-ptpp_pkg::PRESCALE){1'b0}},
                   rho_root, {ptpp_pkg::PRESCALE{1'b0}}};

    // azimuth and elevation
    ptpp_cordic u_theta
    (
        .clk  (clk),
        .en   (en),
        .x_in (th_x),
        .y_in (th_y),
        .ang  (ang_theta)
    );

    ptpp_cordic u_phi
    (
        .clk  (clk),
        .en   (en),
        .x_in (ph_x),
        .y_in (ph_y),
        .ang  (ang_phi)
    );

    // cosine = rho * 2^16 / r, restoring division one quotient bit per stage
    always_comb
    begin
        logic [ptpp_pkg::ROOT_W:0]   d;
        logic [ptpp_pkg::ROOT_W-1:0] dsr;
        logic [ptpp_pkg::COS_W-1:0]  q;
        for (int k = 0; k < ptpp_pkg::DIV_STEPS; k++)
        begin
            if (k == 0)
            begin
                d   = {1'b0, rho_root};
                dsr = r_root;
                q   = '0;
            end
            else
            begin
                d   = {div_rem_reg[k-1], 1'b0};
                dsr = div_dsr_reg[k-1];
                q   = div_quo_reg[k-1];
            end
            div_dsr_next[k] = dsr;
            if (d >= {1'b0, dsr})
            begin
                div_rem_next[k] = ptpp_pkg::ROOT_W'(d - {1'b0, dsr});
                div_quo_next[k] = {q[ptpp_pkg::COS_W-2:0], 1'b1};
            end
            else
            begin
                div_rem_next[k] = d[ptpp_pkg::ROOT_W-1:0];
                div_quo_next[k] = {q[ptpp_pkg::COS_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ptpp_pkg::DIV_STEPS; k++)
            begin
                div_rem_reg[k] <= div_rem_next[k];
                div_dsr_reg[k] <= div_dsr_next[k];
                div_quo_reg[k] <= div_quo_next[k];
            end
        end
    end

    // align angles and cosine at the merge stage
    if (ptpp_pkg::ANG_PAD == 0)
    begin : g_ang_direct
        assign ang_theta_m = ang_theta;
        assign ang_phi_m   = ang_phi;
    end
    else
    begin : g_ang_pad
        logic signed [ptpp_pkg::ANG_W-1:0] pt_reg [ptpp_pkg::ANG_PAD];
        logic signed [ptpp_pkg::ANG_W-1:0] pp_reg [ptpp_pkg::ANG_PAD];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pt_reg[0] <= ang_theta;
                pp_reg[0] <= ang_phi;
                for (int k = 1; k < ptpp_pkg::ANG_PAD; k++)
                begin
                    pt_reg[k] <= pt_reg[k-1];
                    pp_reg[k] <= pp_reg[k-1];
                end
            end
        end
        assign ang_theta_m = pt_reg[ptpp_pkg::ANG_PAD-1];
        assign ang_phi_m   = pp_reg[ptpp_pkg::ANG_PAD-1];
    end

    if (ptpp_pkg::COS_PAD == 0)
    begin : g_cos_direct
        assign cos_m = div_quo_reg[ptpp_pkg::DIV_STEPS-1];
    end
    else
    begin : g_cos_pad
        logic [ptpp_pkg::COS_W-1:0] pc_reg [ptpp_pkg::COS_PAD];
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pc_reg[0] <= div_quo_reg[ptpp_pkg::DIV_STEPS-1];
                for (int k = 1; k < ptpp_pkg::COS_PAD; k++)
                    pc_reg[k] <= pc_reg[k-1];
            end
        end
        assign cos_m = pc_reg[ptpp_pkg::COS_PAD-1];
    end

    // floor of (ph * 2^26 + pl) / 2^48 without the wide sum
    assign col_sum = ptpp_pkg::SUM_W'(ph_reg)
                   + $signed({{(ptpp_pkg::SUM_W-ptpp_pkg::PL_W+ptpp_pkg::LO_W){1'b0}},
                              pl_reg[ptpp_pkg::PL_W-1:ptpp_pkg::LO_W]});

    // pixel arithmetic
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // merge: negate azimuth, origin point takes cosine one
            theta_reg <= -ang_theta_m;
            phi_reg   <= ang_phi_m;
            cos_reg   <= ctrl_reg[ptpp_pkg::S_MERGE-4].zero ? ptpp_pkg::COS_ONE : cos_m;
            // theta * cos and width * phi
            tc_reg    <= theta_reg * $signed({1'b0, cos_reg});
            rp_reg    <= $signed({1'b0, pano_width_reg}) * phi_reg;
            // width times theta * cos in two partial products
            pl_reg    <= pano_width_reg * tc_reg[ptpp_pkg::LO_W-1:0];
            ph_reg    <= $signed({1'b0, pano_width_reg})
                       * $signed(tc_reg[ptpp_pkg::TC_W-1:ptpp_pkg::LO_W]);
            rp2_reg   <= rp_reg;
            // floor shifts
            col_off_reg <= col_sum[ptpp_pkg::SUM_W-1:ptpp_pkg::COL_SHIFT];
            row_off_reg <= rp2_reg[ptpp_pkg::RP_W-1:ptpp_pkg::ROW_SHIFT];
            // center offsets
            col_reg <= ptpp_pkg::PIX_W'(col_off_reg)
                     + ptpp_pkg::PIX_W'({1'b0, pano_width_reg[ptpp_pkg::DIM_W-1:1]});
            row_reg <= ptpp_pkg::PIX_W'(row_off_reg)
                     + ptpp_pkg::PIX_W'({1'b0, pano_height_reg[ptpp_pkg::DIM_W-1:1]});
            // saturation
            col_c_reg <= clamp_pixel(col_reg, pano_width_reg);
            row_c_reg <= clamp_pixel(row_reg, pano_height_reg);
        end
    end

    // finished transaction from the last stage
    assign last_valid    = ctrl_reg[ptpp_pkg::CTRL_LEN-1].valid;
    assign item.in_range = !ctrl_reg[ptpp_pkg::CTRL_LEN-1].near;
    assign item.column   = ctrl_reg[ptpp_pkg::CTRL_LEN-1].near ? '0 : col_c_reg;
    assign item.row      = ctrl_reg[ptpp_pkg::CTRL_LEN-1].near ? '0 : row_c_reg;

    // output register with skid register behind it
    always_comb
    begin
        out_ready       = !out_valid_reg || !out_stall;
        out_from_skid   = skid_valid_reg && out_ready;
        load_out        = !skid_valid_reg && last_valid && out_ready;
        load_skid       = !skid_valid_reg && last_valid && !out_ready;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_from_skid)
            skid_valid_next = 1'b0;
        else if (load_skid)
            skid_valid_next = 1'b1;
        if (out_from_skid || load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_from_skid)
            out_reg <= skid_reg;
        else if (load_out)
            out_reg <= item;
        if (load_skid)
            skid_reg <= item;
    end

    assign out_valid    = out_valid_reg;
    assign in_range     = out_reg.in_range;
    assign pixel_column = out_reg.column;
    assign pixel_row    = out_reg.row;

    // skid register only fills behind a held output
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a transaction while the output is empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid register filled without a stalled output");

    // a parked transaction survives until the output frees up
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_stall |=> skid_valid_reg && out_valid_reg)
        else $error("parked transaction lost during stall");

    // points inside the minimum range report pixel zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.in_range |-> out_reg.column == '0 && out_reg.row == '0)
        else $error("skipped point carries a nonzero pixel");

endmodule
